### design/overwriting_ring_deque_top_assert.svh
// Assertion macros for the overwriting ring deque checker.
`ifndef OVERWRITING_RING_DEQUE_TOP_ASSERT_SVH
`define OVERWRITING_RING_DEQUE_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define ORDQ_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("ordq: same-cycle check failed");

// Next-cycle implication, disabled while reset is high.
`define ORDQ_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("ordq: next-cycle check failed");

`endif

### design/ordq_pkg.sv
// Package: command codes and control types for the overwriting ring deque.
`timescale 1ns / 1ps

package ordq_pkg;

   localparam int CMD_W = 3;

   typedef enum logic [CMD_W-1:0] {
      CMD_PUSH_FRONT = 3'd0,
      CMD_PUSH_BACK  = 3'd1,
      CMD_POP_FRONT  = 3'd2,
      CMD_POP_BACK   = 3'd3,
      CMD_READ       = 3'd4,
      CMD_SET_LEN    = 3'd5
   } cmd_type;

   // Decoded action of one command.
   typedef struct packed {
      logic mem_wr;
      logic mem_rd;
      logic err;
   } exec_ctl_type;

endpackage

### design/ordq_if.sv
// Interfaces: command channel and result channel of the ring deque.
`timescale 1ns / 1ps

interface ordq_req_if #(
   parameter int DATA_W = 32,
   parameter int POS_W  = 5
);
   logic                       valid;
   logic                       ready;
   logic [ordq_pkg::CMD_W-1:0] cmd;
   logic [DATA_W-1:0]          data;
   logic [POS_W-1:0]           position;

   modport source (output valid, cmd, data, position, input ready);
   modport sink   (input valid, cmd, data, position, output ready);
endinterface

interface ordq_rsp_if #(
   parameter int DATA_W = 32,
   parameter int CNT_W  = 5
);
   logic              valid;
   logic              ready;
   logic [DATA_W-1:0] read_data;
   logic [CNT_W-1:0]  count;
   logic              is_full;
   logic              error;

   modport source (output valid, read_data, count, is_full, error, input ready);
   modport sink   (input valid, read_data, count, is_full, error, output ready);
endinterface

### design/overwriting_ring_deque_top.sv
// Top level: overwriting ring deque with one synchronous store memory.
`timescale 1ns / 1ps

// channel   dir  fields                                  accepted when
// req_ch    in   cmd, data, position                     valid && ready
// rsp_ch    out  read_data, count, is_full, error        valid && ready
//
// One item per cycle sustained while the result side does not stall; each result passes stage 1 and the output stage.
// The store is one memory with a registered read; head and length are
// updated in the accept cycle, so no forwarding is needed between items.
// Reset (synchronous) clears head, length and the two stage valid bits only.
// A stalled result stage holds; the command side stalls only when both stages are full.
module overwriting_ring_deque_top #(
   parameter int DEPTH = 16,
   parameter int WIDTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   ordq_req_if.sink    req_ch,
   ordq_rsp_if.source  rsp_ch
);
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int CNT_W  = $clog2(DEPTH+1);
   localparam logic [CNT_W-1:0] FULL_LEN = CNT_W'(DEPTH);

   logic [WIDTH-1:0] store_mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   logic [ADDR_W-1:0] head_ff, head_in;
   logic [CNT_W-1:0]  len_ff, len_in;

   logic              s1_valid_ff, s1_valid_in;
   logic              s1_rd_ff;
   logic              s1_err_ff;
   logic [CNT_W-1:0]  s1_len_ff;

   logic              out_valid_ff, out_valid_in;
   logic [WIDTH-1:0]  out_data_ff;
   logic [CNT_W-1:0]  out_cnt_ff;
   logic              out_full_ff;
   logic              out_err_ff;

   logic              accept;
   logic              s1_go;
   logic [ADDR_W-1:0] mem_addr;
   ordq_pkg::exec_ctl_type ctl;

   ordq_exec #(.DEPTH(DEPTH)) u_exec (
      .cmd         (req_ch.cmd),
      .position    (req_ch.position),
      .head        (head_ff),
      .length      (len_ff),
      .head_next   (head_in),
      .length_next (len_in),
      .mem_addr    (mem_addr),
      .ctl         (ctl)
   );

   assign s1_go        = !out_valid_ff || rsp_ch.ready;
   assign req_ch.ready = !s1_valid_ff || s1_go;
   assign accept       = req_ch.valid && req_ch.ready;
   assign s1_valid_in  = accept || (s1_valid_ff && !s1_go);
   assign out_valid_in = (s1_valid_ff && s1_go) || (out_valid_ff && !rsp_ch.ready);

   // store memory: write for pushes, registered read for reads
   always_ff @(posedge clock) begin
      if (accept && ctl.mem_wr) begin
         store_mem[mem_addr] <= req_ch.data;
      end
      if (accept && ctl.mem_rd) begin
         rdata_ff <= store_mem[mem_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         len_ff       <= '0;
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
         if (accept) begin
            head_ff <= head_in;
            len_ff  <= len_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_rd_ff  <= ctl.mem_rd;
         s1_err_ff <= ctl.err;
         s1_len_ff <= len_in;
      end
      if (s1_valid_ff && s1_go) begin
         out_data_ff <= s1_rd_ff ? rdata_ff : '0;
         out_cnt_ff  <= s1_len_ff;
         out_full_ff <= (s1_len_ff == FULL_LEN);
         out_err_ff  <= s1_err_ff;
      end
   end

   assign rsp_ch.valid     = out_valid_ff;
   assign rsp_ch.read_data = out_data_ff;
   assign rsp_ch.count     = out_cnt_ff;
   assign rsp_ch.is_full   = out_full_ff;
   assign rsp_ch.error     = out_err_ff;

endmodule

### design/ordq_exec.sv
// Command decode: next head, next length, memory address and error for one item.
`timescale 1ns / 1ps

module ordq_exec #(
   parameter int DEPTH = 16
) (
   input  logic [ordq_pkg::CMD_W-1:0]  cmd,
   input  logic [$clog2(DEPTH+1)-1:0]  position,
   input  logic [$clog2(DEPTH)-1:0]    head,
   input  logic [$clog2(DEPTH+1)-1:0]  length,
   output logic [$clog2(DEPTH)-1:0]    head_next,
   output logic [$clog2(DEPTH+1)-1:0]  length_next,
   output logic [$clog2(DEPTH)-1:0]    mem_addr,
   output ordq_pkg::exec_ctl_type      ctl
);
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int CNT_W  = $clog2(DEPTH+1);
   localparam logic [CNT_W-1:0]  FULL_LEN = CNT_W'(DEPTH);
   localparam logic [ADDR_W-1:0] ONE_ADDR = ADDR_W'(1);
   localparam logic [CNT_W-1:0]  ONE_LEN  = CNT_W'(1);

   logic full;
   logic empty;

   assign full  = (length == FULL_LEN);
   assign empty = (length == '0);

   always_comb begin
      head_next   = head;
      length_next = length;
      mem_addr    = head;
      ctl         = '0;
      unique case (ordq_pkg::cmd_type'(cmd))
         ordq_pkg::CMD_PUSH_FRONT: begin
            // when full, the new front lands on the old back entry
            head_next   = head - ONE_ADDR;
            mem_addr    = head - ONE_ADDR;
            length_next = full ? length : length + ONE_LEN;
            ctl.mem_wr  = 1'b1;
         end
         ordq_pkg::CMD_PUSH_BACK: begin
            mem_addr   = head + length[ADDR_W-1:0];
            ctl.mem_wr = 1'b1;
            if (full) begin
               head_next = head + ONE_ADDR;
            end else begin
               length_next = length + ONE_LEN;
            end
         end
         ordq_pkg::CMD_POP_FRONT: begin
            if (empty) begin
               ctl.err = 1'b1;
            end else begin
               head_next   = head + ONE_ADDR;
               length_next = length - ONE_LEN;
            end
         end
         ordq_pkg::CMD_POP_BACK: begin
            if (empty) begin
               ctl.err = 1'b1;
            end else begin
               length_next = length - ONE_LEN;
            end
         end
         ordq_pkg::CMD_READ: begin
            mem_addr = head + position[ADDR_W-1:0];
            if (position >= length) begin
               ctl.err = 1'b1;
            end else begin
               ctl.mem_rd = 1'b1;
            end
         end
         ordq_pkg::CMD_SET_LEN: begin
            if (position > FULL_LEN) begin
               ctl.err = 1'b1;
            end else begin
               length_next = position;
            end
         end
         default: begin
            ctl.err = 1'b1;
         end
      endcase
   end

endmodule

### design/ordq_checker.sv
// Checker on the ring deque ports, bound to the top level.
`timescale 1ns / 1ps
`include "overwriting_ring_deque_top_assert.svh"

module ordq_checker #(
   parameter int DEPTH = 16,
   parameter int WIDTH = 32
) (
   input logic                       clock,
   input logic                       reset,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic [WIDTH-1:0]           rsp_read_data,
   input logic [$clog2(DEPTH+1)-1:0] rsp_count,
   input logic                       rsp_is_full,
   input logic                       rsp_error
);
   localparam int CNT_W = $clog2(DEPTH+1);
   localparam logic [CNT_W-1:0] FULL_LEN = CNT_W'(DEPTH);

   `ORDQ_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_read_data) && $stable(rsp_count) && $stable(rsp_error))
   `ORDQ_ASSERT_NOW(a_count_range, rsp_valid, rsp_count <= FULL_LEN)
   `ORDQ_ASSERT_NOW(a_full_flag, rsp_valid, rsp_is_full == (rsp_count == FULL_LEN))
   `ORDQ_ASSERT_NOW(a_err_no_data, rsp_valid && rsp_error, rsp_read_data == '0)

endmodule

bind overwriting_ring_deque_top ordq_checker #(.DEPTH(DEPTH), .WIDTH(WIDTH)) u_ordq_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_ch.valid),
   .rsp_ready     (rsp_ch.ready),
   .rsp_read_data (rsp_ch.read_data),
   .rsp_count     (rsp_ch.count),
   .rsp_is_full   (rsp_ch.is_full),
   .rsp_error     (rsp_ch.error)
);

### tb/ordq_result_checker.sv
// Checker: predicts each deque result from accepted commands and compares it.
`timescale 1ns / 1ps

module ordq_result_checker (
   input  logic  clock,
   input  logic  reset,
   ordq_req_if   req_ch,
   ordq_rsp_if   rsp_ch,
   output int    mismatch_count,
   output int    pending_results
);

   localparam int DEPTH = 16;

   typedef struct packed {
      logic [31:0] read_data;
      logic [4:0]  count;
      logic        is_full;
      logic        error;
   } deque_result_type;

   logic [31:0]      ring [DEPTH];
   logic [3:0]       front_slot;
   logic [4:0]       fill;
   deque_result_type predicted_results [$];
   int               mismatches = 0;

   // Applies one command to the shadow deque and returns the result it produces.
   function automatic deque_result_type apply_deque_command(logic [2:0] op,
                                                            logic [31:0] value,
                                                            logic [4:0] pos);
      deque_result_type r;
      logic [3:0]       slot;
      r = '0;
      case (op)
         ordq_pkg::CMD_PUSH_FRONT: begin
            front_slot = front_slot - 4'd1;
            if (fill < DEPTH) fill = fill + 5'd1;
            ring[front_slot] = value;
         end
         ordq_pkg::CMD_PUSH_BACK: begin
            slot = front_slot + fill[3:0];
            // full ring: the oldest entry is overwritten and the front moves on
            if (fill == DEPTH) front_slot = front_slot + 4'd1;
            else fill = fill + 5'd1;
            ring[slot] = value;
         end
         ordq_pkg::CMD_POP_FRONT: begin
            if (fill == 0) begin
               r.error = 1'b1;
            end else begin
               front_slot = front_slot + 4'd1;
               fill = fill - 5'd1;
            end
         end
         ordq_pkg::CMD_POP_BACK: begin
            if (fill == 0) r.error = 1'b1;
            else fill = fill - 5'd1;
         end
         ordq_pkg::CMD_READ: begin
            if (pos >= fill) begin
               r.error = 1'b1;
            end else begin
               slot = front_slot + pos[3:0];
               r.read_data = ring[slot];
            end
         end
         ordq_pkg::CMD_SET_LEN: begin
            if (pos > DEPTH) r.error = 1'b1;
            else fill = pos;
         end
         default: r.error = 1'b1;
      endcase
      r.count   = fill;
      r.is_full = (fill == DEPTH);
      return r;
   endfunction

   always @(posedge clock) begin
      deque_result_type exp_r;
      deque_result_type got_r;
      if (reset) begin
         front_slot = '0;
         fill = '0;
         predicted_results.delete();
      end else begin
         // result first: a command's own result never comes back in its accept cycle
         if (rsp_ch.valid && rsp_ch.ready) begin
            got_r = '{rsp_ch.read_data, rsp_ch.count, rsp_ch.is_full, rsp_ch.error};
            if (predicted_results.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("%0t: unexpected result: data %h count %0d full %b err %b",
                           $realtime, got_r.read_data, got_r.count, got_r.is_full,
                           got_r.error);
            end else begin
               exp_r = predicted_results.pop_front();
               if (got_r.read_data !== exp_r.read_data || got_r.count !== exp_r.count ||
                   got_r.is_full !== exp_r.is_full || got_r.error !== exp_r.error) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("%0t: mismatch: exp %h/%0d/%b/%b got %h/%0d/%b/%b",
                              $realtime, exp_r.read_data, exp_r.count, exp_r.is_full,
                              exp_r.error, got_r.read_data, got_r.count, got_r.is_full,
                              got_r.error);
               end
            end
         end
         if (req_ch.valid && req_ch.ready)
            predicted_results.push_back(apply_deque_command(req_ch.cmd, req_ch.data,
                                                            req_ch.position));
      end
      pending_results <= predicted_results.size();
      mismatch_count  <= mismatches;
   end

endmodule

### tb/overwriting_ring_deque_top_tb.sv
// Testbench top: command stimulus, result back-pressure and verdict for the ring deque.
`timescale 1ns / 1ps

module overwriting_ring_deque_top_tb;

   localparam int          DEPTH        = 16;
   localparam int          RANDOM_ITEMS = 1400;
   localparam logic [2:0]  CMD_UNUSED_A = 3'd6;
   localparam logic [2:0]  CMD_UNUSED_B = 3'd7;

   logic clock = 1'b0;
   logic reset;
   int   mismatch_count;
   int   pending_results;
   int   send_burst = 0;
   int   recv_burst = 0;

   // layout of the ring as seen by the stimulus, so reads never hit unwritten slots
   logic [3:0] trk_head = '0;
   logic [4:0] trk_len = '0;
   bit         slot_written [DEPTH];

   ordq_req_if #(.DATA_W(32), .POS_W(5)) req_ch ();
   ordq_rsp_if #(.DATA_W(32), .CNT_W(5)) rsp_ch ();

   overwriting_ring_deque_top #(.DEPTH(DEPTH), .WIDTH(32)) i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   ordq_result_checker i_checker (
      .clock           (clock),
      .reset           (reset),
      .req_ch          (req_ch),
      .rsp_ch          (rsp_ch),
      .mismatch_count  (mismatch_count),
      .pending_results (pending_results)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Idle cycles before the next item; now and then a run of back-to-back items.
   function automatic int pick_gap(ref int burst_left);
      if (burst_left > 0) begin
         burst_left--;
         return 0;
      end
      if ($urandom_range(0, 39) == 0) begin
         burst_left = $urandom_range(10, 40);
         return 0;
      end
      return $urandom_range(0, 10);
   endfunction

   task automatic issue(input logic [2:0] op, input logic [31:0] value, input logic [4:0] pos);
      int         gap;
      logic [3:0] slot;
      gap = pick_gap(send_burst);
      slot = trk_head + pos[3:0];
      if (op == ordq_pkg::CMD_READ && pos < trk_len && !slot_written[slot])
         pos = trk_len + 5'($urandom_range(0, 31 - trk_len));
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid    <= 1'b1;
      req_ch.cmd      <= op;
      req_ch.data     <= value;
      req_ch.position <= pos;
      do @(posedge clock); while (!req_ch.ready);
      case (op)
         ordq_pkg::CMD_PUSH_FRONT: begin
            trk_head = trk_head - 4'd1;
            if (trk_len < DEPTH) trk_len = trk_len + 5'd1;
            slot_written[trk_head] = 1'b1;
         end
         ordq_pkg::CMD_PUSH_BACK: begin
            slot = trk_head + trk_len[3:0];
            slot_written[slot] = 1'b1;
            if (trk_len == DEPTH) trk_head = trk_head + 4'd1;
            else trk_len = trk_len + 5'd1;
         end
         ordq_pkg::CMD_POP_FRONT: begin
            if (trk_len != 0) begin
               trk_head = trk_head + 4'd1;
               trk_len = trk_len - 5'd1;
            end
         end
         ordq_pkg::CMD_POP_BACK: if (trk_len != 0) trk_len = trk_len - 5'd1;
         ordq_pkg::CMD_SET_LEN: if (pos <= DEPTH) trk_len = pos;
         default: ;
      endcase
   endtask

   // Result side: random stalls, one draw per item.
   initial begin
      int stall;
      rsp_ch.ready <= 1'b0;
      @(posedge clock);
      forever begin
         stall = pick_gap(recv_burst);
         if (stall > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!rsp_ch.valid);
      end
   end

   initial begin
      logic [2:0]  op;
      logic [31:0] value;
      logic [4:0]  pos;
      int          pick;
      int          push_w;
      int          pop_w;
      bit          draining;
      reset           <= 1'b1;
      req_ch.valid    <= 1'b0;
      req_ch.cmd      <= ordq_pkg::CMD_PUSH_FRONT;
      req_ch.data     <= '0;
      req_ch.position <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // empty deque: pops, reads, bad lengths and unused codes all rejected; then pushes and reads
      issue(ordq_pkg::CMD_POP_FRONT, 32'h0, 5'd0);
      issue(ordq_pkg::CMD_POP_BACK, 32'h0, 5'd0);
      issue(ordq_pkg::CMD_READ, 32'h0, 5'd0);
      issue(ordq_pkg::CMD_SET_LEN, 32'h0, 5'd17);
      issue(ordq_pkg::CMD_SET_LEN, 32'h0, 5'd31);
      issue(CMD_UNUSED_A, 32'hFFFF_FFFF, 5'd31);
      issue(CMD_UNUSED_B, 32'h0, 5'd0);
      issue(ordq_pkg::CMD_PUSH_BACK, 32'h0000_0000, 5'd0);
      issue(ordq_pkg::CMD_PUSH_BACK, 32'hFFFF_FFFF, 5'd31);
      issue(ordq_pkg::CMD_PUSH_FRONT, 32'hA5A5_A5A5, 5'd0);
      issue(ordq_pkg::CMD_READ, 32'h0, 5'd0);
      issue(ordq_pkg::CMD_READ, 32'h0, 5'd2);
      issue(ordq_pkg::CMD_READ, 32'h0, 5'd3);
      // jump to full, overwrite from both ends, then read, pop and empty it
      issue(ordq_pkg::CMD_SET_LEN, 32'h0, 5'd16);
      issue(ordq_pkg::CMD_PUSH_BACK, 32'h1234_5678, 5'd0);
      issue(ordq_pkg::CMD_PUSH_FRONT, 32'h5A5A_5A5A, 5'd0);
      issue(ordq_pkg::CMD_READ, 32'h0, 5'd0);
      issue(ordq_pkg::CMD_READ, 32'h0, 5'd1);
      issue(ordq_pkg::CMD_READ, 32'h0, 5'd16);
      issue(ordq_pkg::CMD_POP_BACK, 32'h0, 5'd0);
      issue(ordq_pkg::CMD_POP_FRONT, 32'h0, 5'd0);
      issue(ordq_pkg::CMD_SET_LEN, 32'h0, 5'd0);
      issue(ordq_pkg::CMD_READ, 32'h0, 5'd0);
      // growing the length exposes entries with their old contents
      issue(ordq_pkg::CMD_SET_LEN, 32'h0, 5'd2);
      issue(ordq_pkg::CMD_READ, 32'h0, 5'd1);

      draining = 1'b0;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 100 == 0) draining = ($urandom_range(0, 2) == 0);
         push_w = draining ? 8 : 21;
         pop_w  = draining ? 18 : 10;
         pick   = $urandom_range(0, 99);
         value  = ($urandom_range(0, 15) == 0) ? ($urandom_range(0, 1) ? '1 : '0) : $urandom;
         pos    = 5'($urandom_range(0, 31));
         if (pick < push_w) begin
            op = ordq_pkg::CMD_PUSH_FRONT;
         end else if (pick < 2 * push_w) begin
            op = ordq_pkg::CMD_PUSH_BACK;
         end else if (pick < 2 * push_w + pop_w) begin
            op = ordq_pkg::CMD_POP_FRONT;
         end else if (pick < 2 * push_w + 2 * pop_w) begin
            op = ordq_pkg::CMD_POP_BACK;
         end else if (pick < 92) begin
            op = ordq_pkg::CMD_READ;
            if (trk_len > 0 && $urandom_range(0, 4) != 0)
               pos = 5'($urandom_range(0, trk_len - 1));
            else
               pos = 5'($urandom_range(trk_len, 31));
         end else if (pick < 98) begin
            op = ordq_pkg::CMD_SET_LEN;
            pos = ($urandom_range(0, 4) == 0) ? 5'($urandom_range(17, 31))
                                              : 5'($urandom_range(0, DEPTH));
         end else begin
            op = $urandom_range(0, 1) ? CMD_UNUSED_B : CMD_UNUSED_A;
         end
         issue(op, value, pos);
      end
      req_ch.valid <= 1'b0;

      @(posedge clock);
      while (pending_results != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (mismatch_count == 0 && pending_results == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

   initial begin
      #2_000_000;
      $display("TEST FAILED");
      $finish;
   end

endmodule
